// ===== hdl/size_class_buffer_pool_top_defines.svh =====
// ---------------------------------------------------------------------------
// Size class buffer pool: assertion macros
// Shared assertion wrappers; each expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef SIZE_CLASS_BUFFER_POOL_TOP_DEFINES_SVH
`define SIZE_CLASS_BUFFER_POOL_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SCBP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SCBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/scbp_pkg.sv =====
// ---------------------------------------------------------------------------
// Size class buffer pool package
// Fixed field widths, operation and status codes, shared types and helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package scbp_pkg;

  localparam int CLASS_SPACE = 8;
  localparam int CLS_W       = 3;
  localparam int SLOT_SPACE  = 64;
  localparam int SLOT_W      = 6;
  localparam int HANDLE_W    = CLS_W + SLOT_W;
  localparam int DEPTH_W     = 7;
  localparam int LIMIT_W     = 23;
  localparam int SIZE_W      = 22;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int CNT_W       = 7;
  localparam int LIFE_W      = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET [CLASS_SPACE] = '{
    23'd64, 23'd256, 23'd1024, 23'd4096,
    23'd16384, 23'd65536, 23'd262144, 23'd1048576
  };

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RETAIN  = 2'd1,
    OP_RELEASE = 2'd2,
    OP_COW     = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_CLASS   = 2'd1,
    ST_EXHAUSTED  = 2'd2,
    ST_BAD_HANDLE = 2'd3
  } status_t;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_EXEC = 1'b1
  } ctl_state_t;

  typedef logic [CLASS_SPACE-1:0][LIMIT_W-1:0] limit_arr_t;

  // Free stack update for the class latched at read time
  typedef struct packed {
    logic              pop;
    logic              push;
    logic [SLOT_W-1:0] slot;
  } stack_cmd_t;

  // Free stack status for the latched class
  typedef struct packed {
    logic               empty;
    logic [SLOT_W-1:0]  top_slot;
    logic [DEPTH_W-1:0] low_mark;
  } stack_view_t;

  // Slot count of a class: max >> cls, floored at min, capped at the slot space
  function automatic logic [DEPTH_W-1:0] slots_of(input int unsigned max_slots,
                                                  input int unsigned min_slots,
                                                  input logic [CLS_W-1:0] cls);
    int unsigned n;
    n = max_slots >> cls;
    if (n < min_slots) n = min_slots;
    if (n > SLOT_SPACE) n = SLOT_SPACE;
    return DEPTH_W'(n);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/scbp_class_sel.sv =====
// ---------------------------------------------------------------------------
// Size class select
// Picks the lowest class whose limit covers the requested size.
// ---------------------------------------------------------------------------
`default_nettype none

module scbp_class_sel #(
  parameter int NUM_CLASSES = 8
) (
  input  wire scbp_pkg::limit_arr_t           limits,
  input  wire logic [scbp_pkg::SIZE_W-1:0]    size,
  output logic                                fit,
  output logic [scbp_pkg::CLS_W-1:0]          cls
);
  import scbp_pkg::*;

  // Scan from the top class down so the lowest match wins
  always_comb begin
    fit = 1'b0;
    cls = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (limits[c] >= {1'b0, size}) begin
        fit = 1'b1;
        cls = CLS_W'(c);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/scbp_free_stack.sv =====
// ---------------------------------------------------------------------------
// Free slot stacks
// One LIFO per class in a shared synchronous memory, with depth and low
// water mark per class. Positions below the low water mark were never
// popped or written, so the top slot there reads as the position itself.
// ---------------------------------------------------------------------------
`default_nettype none

module scbp_free_stack #(
  parameter int MAX_SLOTS_PER_CLASS = 64,
  parameter int MIN_SLOTS_PER_CLASS = 4
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              rd_en,
  input  wire logic [scbp_pkg::CLS_W-1:0]  rd_cls,
  input  wire scbp_pkg::stack_cmd_t        cmd,
  output scbp_pkg::stack_view_t            view
);
  import scbp_pkg::*;

  localparam int MEM_DEPTH = CLASS_SPACE * SLOT_SPACE;

  logic [SLOT_W-1:0]  stack_mem [MEM_DEPTH];
  logic [SLOT_W-1:0]  rd_data_r;
  logic [CLS_W-1:0]   cls_r;
  logic [DEPTH_W-1:0] depth_r [CLASS_SPACE];
  logic [DEPTH_W-1:0] lw_r    [CLASS_SPACE];

  logic [SLOT_W-1:0]  rd_pos;
  logic [DEPTH_W-1:0] cur_depth;
  logic [DEPTH_W-1:0] cur_lw;
  logic [DEPTH_W-1:0] cur_slots;
  logic [DEPTH_W-1:0] top_pos;
  logic               push_ok;

  // Top of stack position for the class being read
  assign rd_pos    = depth_r[rd_cls][SLOT_W-1:0] - SLOT_W'(1);

  assign cur_depth = depth_r[cls_r];
  assign cur_lw    = lw_r[cls_r];
  assign cur_slots = slots_of(MAX_SLOTS_PER_CLASS, MIN_SLOTS_PER_CLASS, cls_r);
  assign top_pos   = cur_depth - DEPTH_W'(1);
  assign push_ok   = cmd.push && (cur_depth < cur_slots);

  // Memory: registered read, push writes one entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= stack_mem[{rd_cls, rd_pos}];
    end
    if (push_ok) begin
      stack_mem[{cls_r, cur_depth[SLOT_W-1:0]}] <= cmd.slot;
    end
  end

  // Depth and low water mark per class
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r <= '0;
      for (int c = 0; c < CLASS_SPACE; c++) begin
        depth_r[c] <= slots_of(MAX_SLOTS_PER_CLASS, MIN_SLOTS_PER_CLASS, CLS_W'(c));
        lw_r[c]    <= slots_of(MAX_SLOTS_PER_CLASS, MIN_SLOTS_PER_CLASS, CLS_W'(c));
      end
    end else begin
      if (rd_en) begin
        cls_r <= rd_cls;
      end
      if (cmd.pop) begin
        depth_r[cls_r] <= top_pos;
        if (top_pos < cur_lw) begin
          lw_r[cls_r] <= top_pos;
        end
      end else if (push_ok) begin
        depth_r[cls_r] <= cur_depth + DEPTH_W'(1);
      end
    end
  end

  // Resolve the top slot: untouched positions read as their own index
  assign view.empty    = (cur_depth == '0);
  assign view.top_slot = (top_pos < cur_lw) ? top_pos[SLOT_W-1:0] : rd_data_r;
  assign view.low_mark = cur_lw;

endmodule

`default_nettype wire

// ===== hdl/scbp_ref_table.sv =====
// ---------------------------------------------------------------------------
// Reference table
// Per-handle copy flag, reference count and owner tag in one synchronous
// memory. A slot below its class low water mark was never handed out and
// reads with a zero count.
// ---------------------------------------------------------------------------
`default_nettype none

module scbp_ref_table #(
  parameter int REFCOUNT_BITS = 16,
  parameter int OWNER_BITS    = 32
) (
  input  wire                                 clk,
  input  wire                                 rd_en,
  input  wire logic [scbp_pkg::HANDLE_W-1:0]  rd_handle,
  input  wire logic [scbp_pkg::DEPTH_W-1:0]   low_mark,
  input  wire                                 wr_en,
  input  wire logic [scbp_pkg::HANDLE_W-1:0]  wr_handle,
  input  wire                                 wr_copy,
  input  wire logic [REFCOUNT_BITS-1:0]       wr_rc,
  input  wire logic [OWNER_BITS-1:0]          wr_owner,
  output logic                                rd_copy,
  output logic [REFCOUNT_BITS-1:0]            rd_rc,
  output logic [OWNER_BITS-1:0]               rd_owner
);
  import scbp_pkg::*;

  localparam int ENT_W     = 1 + REFCOUNT_BITS + OWNER_BITS;
  localparam int MEM_DEPTH = CLASS_SPACE * SLOT_SPACE;

  logic [ENT_W-1:0]  ref_mem [MEM_DEPTH];
  logic [ENT_W-1:0]  rd_data_r;
  logic [SLOT_W-1:0] rd_slot_r;
  logic              issued;

  // Memory: registered read, one write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ref_mem[rd_handle];
      rd_slot_r <= rd_handle[SLOT_W-1:0];
    end
    if (wr_en) begin
      ref_mem[wr_handle] <= {wr_copy, wr_rc, wr_owner};
    end
  end

  // Mask entries of slots that never left their free stack
  assign issued   = ({1'b0, rd_slot_r} >= low_mark);
  assign rd_copy  = issued & rd_data_r[ENT_W-1];
  assign rd_rc    = issued ? rd_data_r[OWNER_BITS +: REFCOUNT_BITS] : '0;
  assign rd_owner = rd_data_r[OWNER_BITS-1:0];

endmodule

`default_nettype wire

// ===== hdl/size_class_buffer_pool_top.sv =====
// ---------------------------------------------------------------------------
// Size class buffer pool
// Handle allocator with per-class free stacks and reference counts.
// ---------------------------------------------------------------------------
// Each transaction has an accept step and a write-back step. In the accept
// cycle the class is chosen and the free stack and reference table are read;
// the write-back step waits while the output holds an untaken result, then
// updates the entries, writes them back and loads the result into the output
// register. The next transaction is taken once that write-back is done, as the
// two memories are read, modified and written back through single ports. A
// waiting result blocks only the write-back stage; a new transaction can be
// taken behind it. No clearing pass runs after reset; the block is ready at once.
`default_nettype none
`include "size_class_buffer_pool_top_defines.svh"

module size_class_buffer_pool_top #(
  parameter int NUM_CLASSES         = 8,
  parameter int MAX_SLOTS_PER_CLASS = 64,
  parameter int MIN_SLOTS_PER_CLASS = 4,
  parameter int REFCOUNT_BITS       = 16,
  parameter int OWNER_BITS          = 32
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // configuration
  input  wire                                 cfg_we,
  input  wire logic [scbp_pkg::CLS_W-1:0]     cfg_index,
  input  wire logic [scbp_pkg::LIMIT_W-1:0]   cfg_data,
  // request channel
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire logic [scbp_pkg::OP_W-1:0]      in_operation,
  input  wire logic [scbp_pkg::SIZE_W-1:0]    in_request_size,
  input  wire logic [scbp_pkg::HANDLE_W-1:0]  in_handle_in,
  input  wire logic [OWNER_BITS-1:0]          in_owner_tag,
  // result channel
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [scbp_pkg::STATUS_W-1:0]       out_status,
  output logic [scbp_pkg::HANDLE_W-1:0]       out_handle_out,
  output logic                                out_freed,
  output logic [REFCOUNT_BITS-1:0]            out_refcount_after,
  output logic [OWNER_BITS-1:0]               out_owner_out,
  output logic                                out_is_copy
);
  import scbp_pkg::*;

  localparam logic [REFCOUNT_BITS-1:0] REF_MAX = '1;
  localparam logic [REFCOUNT_BITS-1:0] REF_ONE = REFCOUNT_BITS'(1);

  // Configuration registers
  limit_arr_t limits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CLASS_SPACE; c++) begin
        limits_r[c] <= LIMIT_RESET[c];
      end
    end else if (cfg_we) begin
      limits_r[cfg_index] <= cfg_data;
    end
  end

  // Class select and read issue
  logic             fit;
  logic [CLS_W-1:0] fit_cls;
  logic [CLS_W-1:0] rd_cls;
  logic             accept;

  scbp_class_sel #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_class_sel (
    .limits (limits_r),
    .size   (in_request_size),
    .fit    (fit),
    .cls    (fit_cls)
  );

  assign accept = in_valid && in_ready;
  assign rd_cls = (op_t'(in_operation) == OP_ALLOC) ? fit_cls
                                                    : in_handle_in[HANDLE_W-1 -: CLS_W];

  // Control state
  ctl_state_t state_r, state_nxt;
  logic       out_free;
  logic       commit;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state_r == CS_IDLE);
  assign commit   = (state_r == CS_EXEC) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE: begin
        if (in_valid) state_nxt = CS_EXEC;
      end
      CS_EXEC: begin
        if (out_free) state_nxt = CS_IDLE;
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  // Hold the transaction for the write-back cycle
  op_t                 op_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [OWNER_BITS-1:0] tag_r;
  logic                fit_r;
  logic [CLS_W-1:0]    tcls_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= op_t'(in_operation);
      handle_r <= in_handle_in;
      tag_r    <= in_owner_tag;
      fit_r    <= fit;
      tcls_r   <= rd_cls;
    end
  end

  // Memories
  stack_cmd_t            st_cmd;
  stack_view_t           st_view;
  logic                  mt_we;
  logic [HANDLE_W-1:0]   mt_addr;
  logic                  mt_copy;
  logic [REFCOUNT_BITS-1:0] mt_rc;
  logic [OWNER_BITS-1:0] mt_owner;
  logic                  rd_copy;
  logic [REFCOUNT_BITS-1:0] rd_rc;
  logic [OWNER_BITS-1:0] rd_owner;

  scbp_free_stack #(
    .MAX_SLOTS_PER_CLASS (MAX_SLOTS_PER_CLASS),
    .MIN_SLOTS_PER_CLASS (MIN_SLOTS_PER_CLASS)
  ) u_free_stack (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (accept),
    .rd_cls (rd_cls),
    .cmd    (st_cmd),
    .view   (st_view)
  );

  scbp_ref_table #(
    .REFCOUNT_BITS (REFCOUNT_BITS),
    .OWNER_BITS    (OWNER_BITS)
  ) u_ref_table (
    .clk       (clk),
    .rd_en     (accept),
    .rd_handle (in_handle_in),
    .low_mark  (st_view.low_mark),
    .wr_en     (mt_we),
    .wr_handle (mt_addr),
    .wr_copy   (mt_copy),
    .wr_rc     (mt_rc),
    .wr_owner  (mt_owner),
    .rd_copy   (rd_copy),
    .rd_rc     (rd_rc),
    .rd_owner  (rd_owner)
  );

  // Execute: modify the read entries and form the result
  logic [CLS_W-1:0]      hcls;
  logic [SLOT_W-1:0]     hslot;
  logic [HANDLE_W-1:0]   new_handle;
  logic                  bad;
  status_t               res_status;
  logic [HANDLE_W-1:0]   res_handle;
  logic                  res_freed;
  logic [REFCOUNT_BITS-1:0] res_rc;
  logic [OWNER_BITS-1:0] res_owner;
  logic                  res_copy;
  logic                  do_pop;
  logic                  do_push;
  logic                  cnt_inc;
  logic                  cnt_dec;
  logic [REFCOUNT_BITS-1:0] rc_new;

  assign hcls       = handle_r[HANDLE_W-1 -: CLS_W];
  assign hslot      = handle_r[SLOT_W-1:0];
  assign new_handle = {tcls_r, st_view.top_slot};
  assign bad = ({1'b0, hcls} >= (CLS_W + 1)'(NUM_CLASSES))
            || ({1'b0, hslot} >= slots_of(MAX_SLOTS_PER_CLASS, MIN_SLOTS_PER_CLASS, hcls))
            || (rd_rc == '0);

  always_comb begin
    res_status = ST_OK;
    res_handle = '0;
    res_freed  = 1'b0;
    res_rc     = '0;
    res_owner  = '0;
    res_copy   = 1'b0;
    do_pop     = 1'b0;
    do_push    = 1'b0;
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    mt_we      = 1'b0;
    mt_addr    = handle_r;
    mt_copy    = rd_copy;
    mt_rc      = rd_rc;
    mt_owner   = rd_owner;
    rc_new     = rd_rc;
    case (op_r)
      OP_ALLOC: begin
        if (!fit_r) begin
          res_status = ST_NO_CLASS;
        end else if (st_view.empty) begin
          res_status = ST_EXHAUSTED;
        end else begin
          do_pop     = 1'b1;
          cnt_inc    = 1'b1;
          mt_we      = 1'b1;
          mt_addr    = new_handle;
          mt_copy    = 1'b0;
          mt_rc      = REF_ONE;
          mt_owner   = tag_r;
          res_handle = new_handle;
          res_rc     = REF_ONE;
          res_owner  = tag_r;
        end
      end
      OP_RETAIN: begin
        if (bad) begin
          res_status = ST_BAD_HANDLE;
        end else begin
          rc_new     = (rd_rc == REF_MAX) ? rd_rc : rd_rc + REF_ONE;
          mt_we      = 1'b1;
          mt_rc      = rc_new;
          res_handle = handle_r;
          res_rc     = rc_new;
          res_owner  = rd_owner;
        end
      end
      OP_RELEASE: begin
        if (bad) begin
          res_status = ST_BAD_HANDLE;
        end else begin
          rc_new     = rd_rc - REF_ONE;
          mt_we      = 1'b1;
          mt_rc      = rc_new;
          res_handle = handle_r;
          res_rc     = rc_new;
          res_owner  = rd_owner;
          if (rc_new == '0) begin
            do_push   = 1'b1;
            cnt_dec   = 1'b1;
            res_freed = 1'b1;
          end
        end
      end
      OP_COW: begin
        if (bad) begin
          res_status = ST_BAD_HANDLE;
        end else if ((rd_rc > REF_ONE) && !st_view.empty) begin
          do_pop     = 1'b1;
          cnt_inc    = 1'b1;
          mt_we      = 1'b1;
          mt_addr    = new_handle;
          mt_copy    = 1'b1;
          mt_rc      = REF_ONE;
          res_handle = new_handle;
          res_rc     = REF_ONE;
          res_owner  = rd_owner;
          res_copy   = 1'b1;
        end else begin
          res_handle = handle_r;
          res_rc     = rd_rc;
          res_owner  = rd_owner;
        end
      end
      default: res_status = ST_BAD_HANDLE;
    endcase
    // Gate all side effects on the write-back cycle
    mt_we = mt_we && commit;
  end

  assign st_cmd.pop  = do_pop && commit;
  assign st_cmd.push = do_push && commit;
  assign st_cmd.slot = hslot;

  // Per-class usage counters
  logic [CNT_W-1:0]  in_use_r [CLASS_SPACE];
  logic [LIFE_W-1:0] life_r   [CLASS_SPACE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CLASS_SPACE; c++) begin
        in_use_r[c] <= '0;
        life_r[c]   <= '0;
      end
    end else if (commit) begin
      if (cnt_inc) begin
        in_use_r[tcls_r] <= in_use_r[tcls_r] + CNT_W'(1);
        life_r[tcls_r]   <= life_r[tcls_r] + LIFE_W'(1);
      end else if (cnt_dec && (in_use_r[tcls_r] != '0)) begin
        in_use_r[tcls_r] <= in_use_r[tcls_r] - CNT_W'(1);
      end
    end
  end

  // Output register
  logic out_valid_r, out_valid_nxt;

  assign out_valid_nxt = commit || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status         <= res_status;
      out_handle_out     <= res_handle;
      out_freed          <= res_freed;
      out_refcount_after <= res_rc;
      out_owner_out      <= res_owner;
      out_is_copy        <= res_copy;
    end
  end

  assign out_valid = out_valid_r;

  // Checks
  `SCBP_ASSERT_NEXT(a_accept_to_exec, accept, state_r == CS_EXEC, "accepted transaction did not enter write-back")
  `SCBP_ASSERT_IMPL(a_fail_clears, out_valid && (out_status != ST_OK), (out_handle_out == '0) && !out_freed && (out_refcount_after == '0) && (out_owner_out == '0) && !out_is_copy, "failed result carries nonzero fields")
  `SCBP_ASSERT_IMPL(a_freed_zero, out_valid && out_freed, (out_status == ST_OK) && (out_refcount_after == '0), "freed result with nonzero count")
  `SCBP_ASSERT_IMPL(a_copy_one, out_valid && out_is_copy, (out_status == ST_OK) && (out_refcount_after == REF_ONE), "copy result without a single reference")

endmodule

`default_nettype wire

// ===== sim/size_class_buffer_pool_top_tb.sv =====
// ---------------------------------------------------------------------------
// Size class buffer pool testbench
// Drives alloc, retain, release and copy-on-write requests through the
// valid/ready request port. A scoreboard keeps its own model of the free
// stacks, reference counts and owner tags, and checks every result in order.
// Class limits are reprogrammed between traffic phases while the pool is idle.
// ---------------------------------------------------------------------------
module size_class_buffer_pool_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scbp_pkg::*;

  localparam int          NUM_CLASSES       = 8;
  localparam int          REF_W             = 16;
  localparam int          OWNER_W           = 32;
  localparam logic [15:0] REF_MAX           = 16'hFFFF;
  localparam logic [22:0] LIMIT_TOP         = 23'd4194304;
  localparam logic [21:0] SIZE_TOP          = 22'h3FFFFF;
  localparam int          REG_CLASS_LIMIT_0 = 0;
  localparam int          SETTLE_CYCLES     = 6;
  localparam int          LONG_HOLD_CYCLES  = 300;
  localparam int          ITEMS_PER_PHASE   = 150;
  localparam int          BURST_RETAINS     = 24;
  localparam int          CYCLE_LIMIT       = 1000000;

  typedef enum int {
    LIMITS_RESET,
    LIMITS_WIDEST,
    LIMITS_NARROWEST,
    LIMITS_RANDOM,
    LIMITS_SMALL
  } limit_mode_t;

  typedef struct {
    status_t               status;
    logic [HANDLE_W-1:0]   handle;
    logic                  freed;
    logic [REF_W-1:0]      refcnt;
    logic [OWNER_W-1:0]    owner;
    logic                  is_copy;
  } pool_result_t;

  // Shadow of the pool: free stacks, counts and owners; predicts each result
  class pool_scoreboard;
    logic [LIMIT_W-1:0] class_limit [CLASS_SPACE];
    logic [SLOT_W-1:0]  free_stack [CLASS_SPACE][SLOT_SPACE];
    int unsigned        stack_top [CLASS_SPACE];
    logic [REF_W-1:0]   refcnt [CLASS_SPACE*SLOT_SPACE];
    logic [OWNER_W-1:0] owner [CLASS_SPACE*SLOT_SPACE];
    bit                 copy_mark [CLASS_SPACE*SLOT_SPACE];
    int unsigned        in_use [CLASS_SPACE];
    logic [31:0]        lifetime [CLASS_SPACE];
    pool_result_t       expected_q [$];
    logic [HANDLE_W-1:0] last_handle;
    int                 errors, noted, checked, grants, copies, frees, refused;

    function new();
      for (int c = 0; c < CLASS_SPACE; c++) begin
        class_limit[c] = LIMIT_RESET[c];
        stack_top[c]   = class_slots(c);
        in_use[c]      = 0;
        lifetime[c]    = '0;
        for (int k = 0; k < SLOT_SPACE; k++) free_stack[c][k] = SLOT_W'(k);
      end
      for (int h = 0; h < CLASS_SPACE*SLOT_SPACE; h++) begin
        refcnt[h]    = '0;
        owner[h]     = '0;
        copy_mark[h] = 1'b0;
      end
      errors = 0; noted = 0; checked = 0;
      grants = 0; copies = 0; frees = 0; refused = 0;
      last_handle = '0;
    endfunction

    function int unsigned class_slots(int unsigned c);
      int unsigned n;
      n = 64 >> c;
      if (n < 4) n = 4;
      return n;
    endfunction

    // Pop a free slot of class c; -1 when the class is empty
    function int take_slot(int unsigned c, logic [OWNER_W-1:0] tag, bit copy);
      int unsigned h;
      if (stack_top[c] == 0) return -1;
      stack_top[c]--;
      h = c*SLOT_SPACE + free_stack[c][stack_top[c]];
      refcnt[h]    = 1;
      owner[h]     = tag;
      copy_mark[h] = copy;
      in_use[c]    = (in_use[c] + 1) & 32'h7F;
      lifetime[c]  = lifetime[c] + 1;
      grants++;
      return int'(h);
    endfunction

    // Apply one accepted transaction and queue the result it must produce
    function void note_request(op_t op, logic [SIZE_W-1:0] size,
                               logic [HANDLE_W-1:0] h, logic [OWNER_W-1:0] tag);
      pool_result_t r;
      int           got;
      int unsigned  c;
      bit           fit;
      r.status = ST_OK; r.handle = '0; r.freed = 1'b0;
      r.refcnt = '0;    r.owner = '0;  r.is_copy = 1'b0;
      c = h[HANDLE_W-1:SLOT_W];
      noted++;
      if (op == OP_ALLOC) begin
        fit = 1'b0;
        for (int k = 0; k < NUM_CLASSES; k++) begin
          if (!fit && {1'b0, size} <= class_limit[k]) begin
            fit = 1'b1;
            c = k;
          end
        end
        if (!fit) begin
          r.status = ST_NO_CLASS;
        end else begin
          got = take_slot(c, tag, 1'b0);
          if (got < 0) begin
            r.status = ST_EXHAUSTED;
          end else begin
            r.handle = HANDLE_W'(got);
            r.refcnt = 1;
            r.owner  = owner[got];
          end
        end
      end else if (h[SLOT_W-1:0] >= class_slots(c) || refcnt[h] == 0) begin
        r.status = ST_BAD_HANDLE;
      end else if (op == OP_RETAIN) begin
        // saturate at the top count
        if (refcnt[h] != REF_MAX) refcnt[h]++;
        r.handle = h; r.refcnt = refcnt[h]; r.owner = owner[h];
      end else if (op == OP_RELEASE) begin
        refcnt[h]--;
        r.handle = h; r.refcnt = refcnt[h]; r.owner = owner[h];
        if (refcnt[h] == 0) begin
          if (stack_top[c] < class_slots(c)) begin
            free_stack[c][stack_top[c]] = h[SLOT_W-1:0];
            stack_top[c]++;
          end
          if (in_use[c] != 0) in_use[c]--;
          r.freed = 1'b1;
          frees++;
        end
      end else begin
        // copy on write: fresh buffer only when shared and the class has room
        got = -1;
        if (refcnt[h] > 1) got = take_slot(c, owner[h], 1'b1);
        if (got < 0) begin
          r.handle = h; r.refcnt = refcnt[h]; r.owner = owner[h];
        end else begin
          r.handle = HANDLE_W'(got); r.refcnt = 1; r.owner = owner[got];
          r.is_copy = 1'b1;
          copies++;
        end
      end
      if (r.status != ST_OK) refused++;
      last_handle = r.handle;
      expected_q.push_back(r);
    endfunction

    function int pick_live();
      int live [$];
      for (int h = 0; h < CLASS_SPACE*SLOT_SPACE; h++)
        if (refcnt[h] != 0) live.push_back(h);
      if (live.size() == 0) return -1;
      return live[$urandom_range(0, live.size()-1)];
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(logic [STATUS_W-1:0] st, logic [HANDLE_W-1:0] h,
                               logic fr, logic [REF_W-1:0] rc,
                               logic [OWNER_W-1:0] ow, logic cp);
      pool_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: expected none, actual status %h",
                 $time, st);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      check_field("status", 32'(e.status), 32'(st));
      check_field("handle_out", 32'(e.handle), 32'(h));
      check_field("freed", 32'(e.freed), 32'(fr));
      check_field("refcount_after", 32'(e.refcnt), 32'(rc));
      check_field("owner_out", e.owner, ow);
      check_field("is_copy", 32'(e.is_copy), 32'(cp));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CLS_W-1:0]     cfg_index = '0;
  logic [LIMIT_W-1:0]   cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      in_operation = '0;
  logic [SIZE_W-1:0]    in_request_size = '0;
  logic [HANDLE_W-1:0]  in_handle_in = '0;
  logic [OWNER_W-1:0]   in_owner_tag = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [HANDLE_W-1:0]  out_handle_out;
  logic                 out_freed;
  logic [REF_W-1:0]     out_refcount_after;
  logic [OWNER_W-1:0]   out_owner_out;
  logic                 out_is_copy;

  pool_scoreboard pool;
  bit             quiet = 1'b0;
  bit             long_hold_req = 1'b0;
  int             hold_left = 0;
  int             cycles = 0;
  int             settings_run = 0;

  size_class_buffer_pool_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_request_size    (in_request_size),
    .in_handle_in       (in_handle_in),
    .in_owner_tag       (in_owner_tag),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_handle_out     (out_handle_out),
    .out_freed          (out_freed),
    .out_refcount_after (out_refcount_after),
    .out_owner_out      (out_owner_out),
    .out_is_copy        (out_is_copy)
  );

  always #4 clk = ~clk;

  // Stop a hung run
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Result side: check accepted transactions, then choose next ready level
  initial begin
    int r;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        pool.check_result(out_status, out_handle_out, out_freed,
                          out_refcount_after, out_owner_out, out_is_copy);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end else if (hold_left == 0 && !quiet) begin
        r = $urandom_range(0, 99);
        if (r >= 92) hold_left = $urandom_range(10, 40);
        else if (r >= 60) hold_left = $urandom_range(1, 3);
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Drop valid for a random gap after a transaction
  task automatic sender_gap();
    int r, gap;
    if (quiet) return;
    r = $urandom_range(0, 99);
    gap = 0;
    if (r >= 95) gap = $urandom_range(20, 60);
    else if (r >= 70) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Offer one request and hold it until accepted
  task automatic send_request(input op_t op, input logic [SIZE_W-1:0] size,
                              input logic [HANDLE_W-1:0] h,
                              input logic [OWNER_W-1:0] tag);
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_request_size <= size;
    in_handle_in    <= h;
    in_owner_tag    <= tag;
    do @(posedge clk); while (!in_ready);
    pool.note_request(op, size, h, tag);
    sender_gap();
  endtask

  // Hold off new requests until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (pool.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Program all class limits; pool must be idle
  task automatic program_limits(input limit_mode_t mode);
    logic [LIMIT_W-1:0] v;
    for (int c = 0; c < CLASS_SPACE; c++) begin
      case (mode)
        LIMITS_RESET:     v = LIMIT_RESET[c];
        LIMITS_WIDEST:    v = LIMIT_TOP;
        LIMITS_NARROWEST: v = 23'd1;
        LIMITS_RANDOM:    v = LIMIT_W'($urandom_range(1, LIMIT_TOP));
        default:          v = LIMIT_W'($urandom_range(1, 300));
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= CLS_W'(REG_CLASS_LIMIT_0 + c);
      cfg_data  <= v;
      @(posedge clk);
      pool.class_limit[c] = v;
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_run++;
  endtask

  // Request sizes often at or next to a class limit, else random, zero or the top
  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned v;
    v = pool.class_limit[$urandom_range(0, CLASS_SPACE-1)];
    case ($urandom_range(0, 9))
      0:       v = $urandom() & SIZE_TOP;
      1:       v = 0;
      2:       v = SIZE_TOP;
      3, 4:    v = v;
      5:       v = v + 1;
      6:       v = (v > 0) ? v - 1 : 0;
      default: v = $urandom_range(0, v);
    endcase
    if (v > SIZE_TOP) v = SIZE_TOP;
    return SIZE_W'(v);
  endfunction

  // Mostly operations on live handles, with some raw noise
  task automatic random_request();
    int r, h;
    r = $urandom_range(0, 99);
    h = pool.pick_live();
    if (r < 5)
      send_request(op_t'($urandom_range(0, 3)), SIZE_W'($urandom()),
                   HANDLE_W'($urandom()), $urandom());
    else if (r < 35 || h < 0)
      send_request(OP_ALLOC, pick_size(), HANDLE_W'($urandom()), $urandom());
    else if (r < 55)
      send_request(OP_RETAIN, SIZE_W'($urandom()), HANDLE_W'(h), $urandom());
    else if (r < 85)
      send_request(OP_RELEASE, SIZE_W'($urandom()), HANDLE_W'(h), $urandom());
    else
      send_request(OP_COW, SIZE_W'($urandom()), HANDLE_W'(h), $urandom());
  endtask

  initial begin
    logic [HANDLE_W-1:0] h_first, h_top, h_copy, h_sat;
    limit_mode_t         plan [6];
    pool = new();
    plan = '{LIMITS_WIDEST, LIMITS_NARROWEST, LIMITS_RANDOM, LIMITS_SMALL,
             LIMITS_RANDOM, LIMITS_RESET};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset limits, boundaries, each operation and corner case
    send_request(OP_ALLOC, 22'd0, '0, 32'h0000_0000);
    h_first = pool.last_handle;
    send_request(OP_ALLOC, 22'd64, '1, 32'hFFFF_FFFF);
    send_request(OP_ALLOC, 22'd65, '0, 32'hA5A5_5A5A);
    send_request(OP_ALLOC, 22'd1048576, '0, 32'h1234_5678);
    h_top = pool.last_handle;
    send_request(OP_ALLOC, SIZE_TOP, '0, 32'hDEAD_BEEF);
    send_request(OP_RETAIN, '0, h_first, '0);
    send_request(OP_COW, '0, h_first, '0);
    h_copy = pool.last_handle;
    send_request(OP_COW, '0, h_copy, '0);
    send_request(OP_RELEASE, '0, h_first, '0);
    send_request(OP_RELEASE, '0, h_first, '0);
    send_request(OP_RETAIN, '0, h_first, '0);
    send_request(OP_RELEASE, SIZE_TOP, '1, '1);
    send_request(OP_COW, '0, '0, '0);
    repeat (3) send_request(OP_ALLOC, 22'd1048576, '0, $urandom());
    send_request(OP_ALLOC, 22'd1048576, '0, $urandom());
    send_request(OP_RETAIN, '0, h_top, '0);
    send_request(OP_COW, '0, h_top, '0);

    // Back-to-back retains on one handle with no idling on either side
    quiet = 1'b1;
    send_request(OP_ALLOC, 22'd1, '0, 32'h5A5A_A5A5);
    h_sat = pool.last_handle;
    repeat (BURST_RETAINS) send_request(OP_RETAIN, '0, h_sat, '0);
    quiet = 1'b0;
    send_request(OP_RELEASE, '0, h_sat, '0);

    // Random traffic under several limit settings
    foreach (plan[p]) begin
      drain();
      program_limits(plan[p]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 0) quiet = (i < 40);
        if (p == 2 && i == 20) long_hold_req = 1'b1;
        if (p == 3 && i == ITEMS_PER_PHASE/2) drain();
        random_request();
      end
      quiet = 1'b0;
    end

    drain();
    $display("Ran %0d requests over %0d limit settings: %0d grants, %0d copies,",
             pool.noted, settings_run + 1, pool.grants, pool.copies);
    $display("  %0d frees, %0d refused; %0d results checked", pool.frees,
             pool.refused, pool.checked);
    if (pool.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/scbp_pkg.sv
hdl/scbp_class_sel.sv
hdl/scbp_free_stack.sv
hdl/scbp_ref_table.sv
hdl/size_class_buffer_pool_top.sv
sim/size_class_buffer_pool_top_tb.sv
